/* hw/rtl/two_queue_priority_dispatcher_core_defines.svh */
// Assertion macros shared by the dispatcher RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef TWO_QUEUE_PRIORITY_DISPATCHER_CORE_DEFINES_SVH
`define TWO_QUEUE_PRIORITY_DISPATCHER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TQPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TQPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tqpd_pkg.sv */
// Types and constants of the two-queue priority dispatcher.
// Depends on nothing; used by tqpd_cmp and the top level of the block.
package tqpd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int LOAD_W    = 8;
    localparam int ID_W      = 8;
    localparam int COUNT_W   = 5;
    localparam int LIMIT_W   = 4;

    localparam logic OP_ENQ   = 1'b0;
    localparam logic OP_DSP   = 1'b1;
    localparam logic DIR_EAST = 1'b0;
    localparam logic DIR_WEST = 1'b1;

    localparam logic [LIMIT_W-1:0] STREAK_MAX  = 4'd15;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [LIMIT_W-1:0] t_limit;

    typedef struct packed {
        logic              prio;
        logic [LOAD_W-1:0] load;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic              opcode;
        logic              direction;
        logic              priority_req;
        logic [LOAD_W-1:0] load_time;
        logic [ID_W-1:0]   entry_id;
    } t_in_word;

    typedef struct packed {
        logic            granted;
        logic [ID_W-1:0] grant_id;
        logic            grant_direction;
        logic            grant_priority;
        logic            dropped;
        t_count          east_count;
        t_count          west_count;
    } t_out_word;

endpackage

/* hw/rtl/tqpd_cmp.sv */
// Shared ordering compare: priority high first, then smaller load, then smaller id.
// Depends on tqpd_pkg.
module tqpd_cmp (
    input  tqpd_pkg::t_entry i_a,
    input  tqpd_pkg::t_entry i_b,
    output logic             o_before
);

    always_comb begin
        if (i_a.prio != i_b.prio) begin
            o_before = i_a.prio & ~i_b.prio;
        end else if (i_a.load != i_b.load) begin
            o_before = i_a.load < i_b.load;
        end else begin
            o_before = i_a.id < i_b.id;
        end
    end

endmodule

/* hw/rtl/tqpd_ram.sv */
// Queue storage: one write port, one read port with registered read data.
// Depends on nothing.
module tqpd_ram #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 17
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/two_queue_priority_dispatcher_core.sv */
// Top level of the two-queue priority dispatcher: sequencer, fill counts, streak.
// Depends on tqpd_pkg, tqpd_cmp, tqpd_ram and the defines header.
//
//  channel | valid    | stall    | payload    | accepted when
//  input   | i_valid  | o_stall  | i_in       | i_valid & !o_stall
//  output  | o_valid  | i_stall  | o_out      | o_valid & !i_stall
//  config  | i_cfg_we | -        | i_cfg_data | i_cfg_we
//
// One word at a time; o_stall is high from acceptance until the result is loaded.
// Enqueue: walks from the tail, moving each entry that ranks behind the new one back one slot; full drops it.
// Dispatch: reads both heads, grants one and moves the served queue up one slot; both empty gives no grant.
// The single memory port pair moves one entry at a time: a read state, then a write state.
// Synchronous active-low reset empties both queues; no clearing pass.
// A held output word does not block acceptance; the result waits until taken.
`include "two_queue_priority_dispatcher_core_defines.svh"

module two_queue_priority_dispatcher_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  tqpd_pkg::t_in_word    i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tqpd_pkg::t_out_word   o_out,
    input  logic                  i_cfg_we,
    input  tqpd_pkg::t_limit      i_cfg_data
);

    localparam int IDX_W  = (tqpd_pkg::QUEUE_DEPTH > 2) ? $clog2(tqpd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(tqpd_pkg::QUEUE_DEPTH + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int ENT_W  = $bits(tqpd_pkg::t_entry);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(tqpd_pkg::QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS_RD  = 9'b000000010,
        S_INS_CMP = 9'b000000100,
        S_DSP_RDE = 9'b000001000,
        S_DSP_RDW = 9'b000010000,
        S_DSP_SEL = 9'b000100000,
        S_DEQ_RD  = 9'b001000000,
        S_DEQ_WR  = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    tqpd_pkg::t_in_word  r_item, n_item;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_fill_e, n_fill_e;
    logic [CNT_W-1:0]    r_fill_w, n_fill_w;
    tqpd_pkg::t_limit    r_streak, n_streak;
    logic                r_last, n_last;
    tqpd_pkg::t_limit    r_limit, n_limit;
    tqpd_pkg::t_entry    r_head_e, n_head_e;
    tqpd_pkg::t_entry    r_grant, n_grant;
    logic                r_gnt, n_gnt;
    logic                r_drop, n_drop;
    logic                r_serve, n_serve;
    tqpd_pkg::t_out_word r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ENT_W-1:0]    ram_wdata, ram_rdata;
    tqpd_pkg::t_entry    rd_entry, new_entry, cmp_a, cmp_b;
    logic                cmp_before;

    logic [CNT_W-1:0]    in_fill, item_fill, serve_fill, idx_m1, idx_p1;
    logic                east_ok, west_ok, forced, other, other_ok, serve;

    tqpd_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tqpd_cmp u_cmp (
        .i_a      (cmp_a),
        .i_b      (cmp_b),
        .o_before (cmp_before)
    );

    assign rd_entry   = tqpd_pkg::t_entry'(ram_rdata);
    assign new_entry  = '{prio: r_item.priority_req, load: r_item.load_time,
                          id: r_item.entry_id};
    assign in_fill    = (i_in.direction == tqpd_pkg::DIR_EAST) ? r_fill_e : r_fill_w;
    assign item_fill  = (r_item.direction == tqpd_pkg::DIR_EAST) ? r_fill_e : r_fill_w;
    assign serve_fill = (r_serve == tqpd_pkg::DIR_EAST) ? r_fill_e : r_fill_w;
    assign idx_m1     = r_idx - ONE;
    assign idx_p1     = r_idx + ONE;
    assign east_ok    = r_fill_e != '0;
    assign west_ok    = r_fill_w != '0;
    assign forced     = r_streak >= r_limit;
    assign other      = ~r_last;
    assign other_ok   = (other == tqpd_pkg::DIR_EAST) ? east_ok : west_ok;

    always_comb begin
        if (forced) begin
            serve = other_ok ? other : r_last;
        end else if (east_ok && (!west_ok || cmp_before)) begin
            serve = tqpd_pkg::DIR_EAST;
        end else begin
            serve = tqpd_pkg::DIR_WEST;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_fill_e    = r_fill_e;
        n_fill_w    = r_fill_w;
        n_streak    = r_streak;
        n_last      = r_last;
        n_limit     = i_cfg_we ? i_cfg_data : r_limit;
        n_head_e    = r_head_e;
        n_grant     = r_grant;
        n_gnt       = r_gnt;
        n_drop      = r_drop;
        n_serve     = r_serve;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        cmp_a       = rd_entry;
        cmp_b       = new_entry;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item  = i_in;
                    n_gnt   = 1'b0;
                    n_drop  = 1'b0;
                    n_grant = '0;
                    n_serve = tqpd_pkg::DIR_EAST;
                    if (i_in.opcode == tqpd_pkg::OP_ENQ) begin
                        if (in_fill == FULL) begin
                            n_drop  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_idx   = in_fill;
                            n_state = S_INS_RD;
                        end
                    end else if (!east_ok && !west_ok) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DSP_RDE;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_item.direction, IDX_W'(0)};
                    ram_wdata = new_entry;
                    if (r_item.direction == tqpd_pkg::DIR_EAST) begin
                        n_fill_e = item_fill + ONE;
                    end else begin
                        n_fill_w = item_fill + ONE;
                    end
                    n_state = S_DONE;
                end else begin
                    ram_raddr = {r_item.direction, idx_m1[IDX_W-1:0]};
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = {r_item.direction, r_idx[IDX_W-1:0]};
                if (cmp_before) begin
                    ram_wdata = new_entry;
                    if (r_item.direction == tqpd_pkg::DIR_EAST) begin
                        n_fill_e = item_fill + ONE;
                    end else begin
                        n_fill_w = item_fill + ONE;
                    end
                    n_state = S_DONE;
                end else begin
                    ram_wdata = ram_rdata;
                    n_idx     = idx_m1;
                    n_state   = S_INS_RD;
                end
            end
            S_DSP_RDE: begin
                ram_raddr = {tqpd_pkg::DIR_EAST, IDX_W'(0)};
                n_state   = S_DSP_RDW;
            end
            S_DSP_RDW: begin
                n_head_e  = rd_entry;
                ram_raddr = {tqpd_pkg::DIR_WEST, IDX_W'(0)};
                n_state   = S_DSP_SEL;
            end
            S_DSP_SEL: begin
                cmp_a = '{prio: r_head_e.prio, load: '0, id: '0};
                cmp_b = '{prio: rd_entry.prio, load: '0, id: '0};
                if (serve == r_last) begin
                    if (r_streak != tqpd_pkg::STREAK_MAX) begin
                        n_streak = r_streak + 4'd1;
                    end
                end else begin
                    n_last   = serve;
                    n_streak = 4'd1;
                end
                n_serve = serve;
                n_grant = (serve == tqpd_pkg::DIR_EAST) ? r_head_e : rd_entry;
                n_gnt   = 1'b1;
                n_idx   = '0;
                n_state = S_DEQ_RD;
            end
            S_DEQ_RD: begin
                if (idx_p1 >= serve_fill) begin
                    if (r_serve == tqpd_pkg::DIR_EAST) begin
                        n_fill_e = r_fill_e - ONE;
                    end else begin
                        n_fill_w = r_fill_w - ONE;
                    end
                    n_state = S_DONE;
                end else begin
                    ram_raddr = {r_serve, idx_p1[IDX_W-1:0]};
                    n_state   = S_DEQ_WR;
                end
            end
            S_DEQ_WR: begin
                ram_we    = 1'b1;
                ram_waddr = {r_serve, r_idx[IDX_W-1:0]};
                ram_wdata = ram_rdata;
                n_idx     = idx_p1;
                n_state   = S_DEQ_RD;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.granted         = r_gnt;
                    n_out.grant_id        = r_grant.id;
                    n_out.grant_direction = r_serve;
                    n_out.grant_priority  = r_grant.prio;
                    n_out.dropped         = r_drop;
                    n_out.east_count      = tqpd_pkg::t_count'(r_fill_e);
                    n_out.west_count      = tqpd_pkg::t_count'(r_fill_w);
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill_e    <= '0;
            r_fill_w    <= '0;
            r_streak    <= '0;
            r_last      <= tqpd_pkg::DIR_WEST;
            r_limit     <= tqpd_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_e    <= n_fill_e;
            r_fill_w    <= n_fill_w;
            r_streak    <= n_streak;
            r_last      <= n_last;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_idx    <= n_idx;
        r_head_e <= n_head_e;
        r_grant  <= n_grant;
        r_gnt    <= n_gnt;
        r_drop   <= n_drop;
        r_serve  <= n_serve;
        r_out    <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    `TQPD_ASSERT_NEXT(a_full_drop,
        (r_state == S_IDLE) && i_valid && (i_in.opcode == tqpd_pkg::OP_ENQ) && (in_fill == FULL),
        r_drop && $stable(r_fill_e) && $stable(r_fill_w), "full enqueue changed a fill count")
    `TQPD_ASSERT_NEXT(a_done_load,
        (r_state == S_DONE) && (!r_out_valid || !i_stall),
        o_valid && (r_state == S_IDLE), "finished word not loaded")
    `TQPD_ASSERT_NOW(a_grant_streak,
        (r_state == S_DONE) && r_gnt, (r_streak != '0) && (r_last == r_serve),
        "grant without streak update")
    `TQPD_ASSERT_NOW(a_grant_nodrop,
        o_valid && o_out.granted, !o_out.dropped, "word both granted and dropped")

endmodule

/* verif/two_queue_priority_dispatcher_core_tb.sv */
// Testbench for two_queue_priority_dispatcher_core: an in-bench model of both sorted queues
// and the streak arbiter predicts every output word, and random idling exercises the handshakes.
// Depends on tqpd_pkg and the dispatcher RTL.
module two_queue_priority_dispatcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tqpd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_in;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_out;
    logic      i_cfg_we;
    t_limit    i_cfg_data;

    two_queue_priority_dispatcher_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    t_entry    queue_slots[2][QUEUE_DEPTH];
    int        queue_fill[2];
    t_limit    model_streak;
    logic      model_last;
    t_limit    model_limit;
    t_out_word predicted_outcomes[$];

    int cycle_count;
    int errors;
    int words_sent;
    int results_checked;
    int grants_seen;
    int drops_seen;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit ranks_ahead(t_entry a, t_entry b);
        if (a.prio != b.prio) return a.prio > b.prio;
        if (a.load != b.load) return a.load < b.load;
        return a.id < b.id;
    endfunction

    function automatic t_out_word dispatch_predict(t_in_word w);
        t_out_word r;
        t_entry    e;
        int        pos;
        logic      d;
        logic      serve;
        logic      other;
        r = '0;
        d = w.direction;
        if (w.opcode == OP_ENQ) begin
            e.prio = w.priority_req;
            e.load = w.load_time;
            e.id   = w.entry_id;
            if (queue_fill[d] >= QUEUE_DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < queue_fill[d] && ranks_ahead(queue_slots[d][pos], e)) pos++;
                for (int k = queue_fill[d]; k > pos; k--)
                    queue_slots[d][k] = queue_slots[d][k-1];
                queue_slots[d][pos] = e;
                queue_fill[d]++;
            end
        end else if (queue_fill[DIR_EAST] != 0 || queue_fill[DIR_WEST] != 0) begin
            if (model_streak >= model_limit) begin
                other = ~model_last;
                if (queue_fill[other] != 0) begin
                    serve        = other;
                    model_last   = other;
                    model_streak = 4'd1;
                end else begin
                    serve = model_last;
                    if (model_streak < STREAK_MAX) model_streak++;
                end
            end else begin
                if (queue_fill[DIR_EAST] != 0 && (queue_fill[DIR_WEST] == 0 ||
                        queue_slots[DIR_EAST][0].prio > queue_slots[DIR_WEST][0].prio)) begin
                    serve = DIR_EAST;
                end else begin
                    serve = DIR_WEST;
                end
                if (serve == model_last) begin
                    if (model_streak < STREAK_MAX) model_streak++;
                end else begin
                    model_last   = serve;
                    model_streak = 4'd1;
                end
            end
            e = queue_slots[serve][0];
            for (int k = 0; k < queue_fill[serve] - 1; k++)
                queue_slots[serve][k] = queue_slots[serve][k+1];
            queue_fill[serve]--;
            r.granted         = 1'b1;
            r.grant_id        = e.id;
            r.grant_direction = serve;
            r.grant_priority  = e.prio;
        end
        r.east_count = t_count'(queue_fill[DIR_EAST]);
        r.west_count = t_count'(queue_fill[DIR_WEST]);
        return r;
    endfunction

    function automatic string word_text(t_out_word w);
        return $sformatf("grant %0d id %0d dir %0d prio %0d drop %0d east %0d west %0d",
                         w.granted, w.grant_id, w.grant_direction, w.grant_priority,
                         w.dropped, w.east_count, w.west_count);
    endfunction

    function automatic void check_result(t_out_word got);
        t_out_word want;
        results_checked++;
        if (predicted_outcomes.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected output word: %s", word_text(got));
            return;
        end
        want = predicted_outcomes.pop_front();
        if (got.granted !== want.granted || got.grant_id !== want.grant_id ||
                got.grant_direction !== want.grant_direction ||
                got.grant_priority !== want.grant_priority || got.dropped !== want.dropped ||
                got.east_count !== want.east_count || got.west_count !== want.west_count) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch %0d: expected %s", errors, word_text(want));
                $display("             actual   %s", word_text(got));
            end
        end
    endfunction

    // receiver: random stall, or a long hold when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_stall = 1'b1;
                rx_hold_left--;
            end else begin
                i_stall = ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (i_rst_n && o_valid && !i_stall) check_result(o_out);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    task automatic send_word(t_in_word w);
        int gap;
        t_out_word r;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_in    = w;
        do @(posedge i_clk); while (o_stall);
        r = dispatch_predict(w);
        predicted_outcomes.push_back(r);
        words_sent++;
        if (r.granted) grants_seen++;
        if (r.dropped) drops_seen++;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (predicted_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_streak_limit(t_limit v);
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        model_limit = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_in_word make_word(logic op, logic d, logic p, int ld, int id);
        t_in_word w;
        w.opcode       = op;
        w.direction    = d;
        w.priority_req = p;
        w.load_time    = ld[LOAD_W-1:0];
        w.entry_id     = id[ID_W-1:0];
        return w;
    endfunction

    // narrow keys half the time so ties on load and id occur
    function automatic t_in_word random_entry(logic d);
        if ($urandom_range(0, 1))
            return make_word(OP_ENQ, d, 1'($urandom_range(0, 1)), $urandom_range(0, 3),
                             $urandom_range(0, 7));
        return make_word(OP_ENQ, d, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                         $urandom_range(0, 255));
    endfunction

    function automatic t_in_word random_dispatch();
        return make_word(OP_DSP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    task automatic test_directed();
        send_word(make_word(OP_DSP, DIR_WEST, 1'b1, 255, 255));
        send_word(make_word(OP_ENQ, DIR_EAST, 1'b1, 255, 255));
        send_word(make_word(OP_ENQ, DIR_EAST, 1'b0, 0, 0));
        send_word(make_word(OP_ENQ, DIR_EAST, 1'b1, 0, 128));
        send_word(make_word(OP_ENQ, DIR_EAST, 1'b1, 0, 127));
        send_word(make_word(OP_ENQ, DIR_WEST, 1'b1, 0, 0));
        send_word(make_word(OP_ENQ, DIR_WEST, 1'b1, 0, 0));
        send_word(make_word(OP_ENQ, DIR_WEST, 1'b0, 255, 255));
        send_word(make_word(OP_ENQ, DIR_WEST, 1'b0, 255, 0));
        repeat (9) send_word(make_word(OP_DSP, DIR_EAST, 1'b0, 0, 0));
        send_word(make_word(OP_DSP, DIR_EAST, 1'b0, 0, 0));
    endtask

    // fill one side past full, add up to two entries to the other, drain both to run up the streak, then probe the turn
    task automatic test_fill_and_drain(int rounds);
        logic d;
        int extra;
        for (int r = 0; r < rounds; r++) begin
            d = 1'($urandom_range(0, 1));
            extra = $urandom_range(1, 3);
            repeat (QUEUE_DEPTH + extra) send_word(random_entry(d));
            repeat ($urandom_range(0, 2)) send_word(random_entry(~d));
            while (queue_fill[DIR_EAST] + queue_fill[DIR_WEST] > 0) send_word(random_dispatch());
            send_word(random_dispatch());
            send_word(random_entry(DIR_EAST));
            send_word(random_entry(DIR_WEST));
            repeat (3) send_word(random_dispatch());
        end
    endtask

    task automatic test_random_mix(int count);
        int dsp_pct;
        int east_pct;
        dsp_pct  = 40;
        east_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                dsp_pct  = $urandom_range(15, 70);
                east_pct = $urandom_range(10, 90);
            end
            if ($urandom_range(0, 99) < dsp_pct)
                send_word(random_dispatch());
            else
                send_word(random_entry($urandom_range(0, 99) >= east_pct));
        end
    endtask

    task automatic test_backpressure();
        rx_hold_left = 300;
        repeat (30) send_word(random_entry(1'($urandom_range(0, 1))));
        repeat (10) send_word(random_dispatch());
    endtask

    task automatic test_drain_pause();
        test_random_mix(20);
        wait_for_drain();
        test_random_mix(20);
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_in         = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = LIMIT_RESET;
        errors       = 0;
        words_sent   = 0;
        results_checked = 0;
        grants_seen  = 0;
        drops_seen   = 0;
        rx_hold_left = 0;
        set_idling(0, 0);
        queue_fill[DIR_EAST] = 0;
        queue_fill[DIR_WEST] = 0;
        model_streak = '0;
        model_last   = DIR_WEST;
        model_limit  = LIMIT_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();

        set_streak_limit(4'd1);
        set_idling(0, 0);
        test_fill_and_drain(3);
        test_random_mix(200);

        set_streak_limit(4'd15);
        set_idling(65, 0);
        test_fill_and_drain(3);
        test_random_mix(200);

        set_streak_limit(4'd0);
        set_idling(0, 65);
        test_fill_and_drain(2);
        test_random_mix(150);

        set_streak_limit(t_limit'($urandom_range(2, 14)));
        set_idling(24, 24);
        test_fill_and_drain(3);
        test_random_mix(200);

        set_streak_limit(t_limit'($urandom_range(1, 15)));
        set_idling(0, 0);
        test_backpressure();
        set_idling(24, 24);
        test_drain_pause();

        wait_for_drain();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d words, %0d results checked, %0d grants, %0d drops.",
                 words_sent, results_checked, grants_seen, drops_seen);
        $display("Streak limits 3, 1, 15, 0 and random; idling off, sender, receiver, both, long hold.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
